@@ sv/fta_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed-timestep accumulator package
// Shared types, widths and constants for the accumulator controller,
// datapath, divider and register block.
// ----------------------------------------------------------------------------
package fta_pkg;

  // Field and register widths.
  localparam int unsigned RateW     = 10;
  localparam int unsigned MaxDeltaW = 30;
  localparam int unsigned CatchW    = 7;
  localparam int unsigned DeltaW    = 32;
  localparam int unsigned AccW      = 32;
  localparam int unsigned PeriodW   = 25;
  localparam int unsigned CountW    = 64;
  localparam int unsigned AlphaW    = 17;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;

  // Divider widths.
  localparam int unsigned NumW  = 32;
  localparam int unsigned QuoW  = 30;
  localparam int unsigned StepW = 6;

  // Arithmetic constants.
  localparam logic [MaxDeltaW-1:0] NS_PER_SECOND      = 30'd1_000_000_000;
  localparam logic [RateW-1:0]     MIN_TICK_RATE      = 10'd30;
  localparam logic [RateW-1:0]     FALLBACK_TICK_RATE = 10'd120;
  localparam logic [MaxDeltaW-1:0] FALLBACK_MAX_DELTA = 30'd100_000_000;
  localparam logic [AlphaW-1:0]    ALPHA_ONE          = 17'd65536;

  // Step counts of the shared divider for each operation.
  localparam logic [StepW-1:0] PERIOD_STEPS = 6'd30;
  localparam logic [StepW-1:0] MOD_STEPS    = 6'd32;
  localparam logic [StepW-1:0] ALPHA_STEPS  = 6'd16;

  // Register indexes.
  localparam logic [1:0] REG_TICK_RATE    = 2'd0;
  localparam logic [1:0] REG_MAX_DELTA    = 2'd1;
  localparam logic [1:0] REG_MAX_CATCH_UP = 2'd2;

  // Register reset values.
  localparam logic [RateW-1:0]     RST_TICK_RATE    = 10'd120;
  localparam logic [MaxDeltaW-1:0] RST_MAX_DELTA    = 30'd100_000_000;
  localparam logic [CatchW-1:0]    RST_MAX_CATCH_UP = 7'd5;

  // Operation of the shared divider.
  typedef enum logic [1:0] {
    DIV_PERIOD = 2'd0,
    DIV_MOD    = 2'd1,
    DIV_ALPHA  = 2'd2
  } div_mode_e;

  // Configuration register contents.
  typedef struct packed {
    logic [RateW-1:0]     tick_rate;
    logic [MaxDeltaW-1:0] max_delta;
    logic [CatchW-1:0]    max_catch_up;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      period_load;
    logic      acc_add;
    logic      tick_step;
    logic      div_start;
    div_mode_e div_mode;
    logic      mod_load;
    logic      alpha_load;
    logic      out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic period_ok;
    logic can_tick;
    logic need_mod;
    logic div_done;
  } stat_t;

endpackage

@@ sv/fta_regs.sv @@
// ----------------------------------------------------------------------------
// Fixed-timestep accumulator configuration registers
// APB-style register block holding tick rate, maximum delta and catch-up
// limit, with a strobe that flags writes to the tick rate.
// ----------------------------------------------------------------------------
module fta_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fta_pkg::AddrW-1:0]  paddr,
  input  logic [fta_pkg::DataW-1:0]  pwdata,
  output logic [fta_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output fta_pkg::cfg_t              cfg_o,
  output logic                       rate_wr_o
);

  fta_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  // Register write decode; writes to unused addresses are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        fta_pkg::REG_TICK_RATE:    cfg_d.tick_rate    = pwdata[fta_pkg::RateW-1:0];
        fta_pkg::REG_MAX_DELTA:    cfg_d.max_delta    = pwdata[fta_pkg::MaxDeltaW-1:0];
        fta_pkg::REG_MAX_CATCH_UP: cfg_d.max_catch_up = pwdata[fta_pkg::CatchW-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_rate    <= fta_pkg::RST_TICK_RATE;
      cfg_q.max_delta    <= fta_pkg::RST_MAX_DELTA;
      cfg_q.max_catch_up <= fta_pkg::RST_MAX_CATCH_UP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read data mux.
  always_comb begin
    unique case (idx)
      fta_pkg::REG_TICK_RATE:
        prdata = {{(fta_pkg::DataW-fta_pkg::RateW){1'b0}}, cfg_q.tick_rate};
      fta_pkg::REG_MAX_DELTA:
        prdata = {{(fta_pkg::DataW-fta_pkg::MaxDeltaW){1'b0}}, cfg_q.max_delta};
      fta_pkg::REG_MAX_CATCH_UP:
        prdata = {{(fta_pkg::DataW-fta_pkg::CatchW){1'b0}}, cfg_q.max_catch_up};
      default:
        prdata = '0;
    endcase
  end

  assign cfg_o     = cfg_q;
  assign rate_wr_o = wr_en && (idx == fta_pkg::REG_TICK_RATE);

endmodule

@@ sv/fta_div.sv @@
// ----------------------------------------------------------------------------
// Fixed-timestep accumulator divider
// Radix-2 restoring divider, one quotient bit per cycle, with a loadable
// starting remainder and a per-operation step count.
// ----------------------------------------------------------------------------
module fta_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fta_pkg::PeriodW-1:0]  init_rem_i,
  input  logic [fta_pkg::NumW-1:0]     dividend_i,
  input  logic [fta_pkg::StepW-1:0]    steps_i,
  input  logic [fta_pkg::PeriodW-1:0]  divisor_i,
  output logic [fta_pkg::QuoW-1:0]     quotient_o,
  output logic [fta_pkg::PeriodW-1:0]  remainder_o,
  output logic                         done_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [fta_pkg::StepW-1:0]   cnt_q, cnt_d;
  logic [fta_pkg::PeriodW-1:0] rem_q, rem_d;
  logic [fta_pkg::PeriodW-1:0] dsr_q, dsr_d;
  logic [fta_pkg::NumW-1:0]    num_q, num_d;
  logic [fta_pkg::QuoW-1:0]    quo_q, quo_d;
  logic [fta_pkg::PeriodW:0]   trial;
  logic [fta_pkg::PeriodW:0]   diff;
  logic                        fits;

  // One shift-and-subtract step.
  assign trial = {rem_q, num_q[fta_pkg::NumW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    num_d  = num_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      rem_d  = init_rem_i;
      dsr_d  = divisor_i;
      num_d  = dividend_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[fta_pkg::PeriodW-1:0] : trial[fta_pkg::PeriodW-1:0];
      num_d = {num_q[fta_pkg::NumW-2:0], 1'b0};
      quo_d = {quo_q[fta_pkg::QuoW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == fta_pkg::StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

@@ sv/fta_dpath.sv @@
// ----------------------------------------------------------------------------
// Fixed-timestep accumulator datapath
// Delta clamp, time accumulator, tick and frame counters, cached period,
// shared divider and the output register.
// ----------------------------------------------------------------------------
module fta_dpath #(
  parameter int unsigned MAX_CATCH_UP_LIMIT = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fta_pkg::cfg_t                     cfg_i,
  input  logic                              rate_wr_i,
  input  fta_pkg::cmd_t                     cmd_i,
  output fta_pkg::stat_t                    stat_o,
  input  logic signed [fta_pkg::DeltaW-1:0] delta_ns_i,
  output logic [fta_pkg::CountW-1:0]        frame_number_o,
  output logic [fta_pkg::CountW-1:0]        sim_tick_count_o,
  output logic [$clog2(MAX_CATCH_UP_LIMIT+1)-1:0] ticks_taken_o,
  output logic signed [fta_pkg::DeltaW-1:0] raw_delta_ns_o,
  output logic [fta_pkg::MaxDeltaW-1:0]     clamped_delta_ns_o,
  output logic [fta_pkg::AlphaW-1:0]        blend_alpha_o
);

  localparam int unsigned TickW = $clog2(MAX_CATCH_UP_LIMIT + 1);
  localparam int unsigned CmpW  = (TickW > fta_pkg::CatchW) ? TickW : fta_pkg::CatchW;

  // Working state.
  logic signed [fta_pkg::DeltaW-1:0] raw_q;
  logic [fta_pkg::MaxDeltaW-1:0]     clamped_q, clamped_d;
  logic [fta_pkg::AccW-1:0]          acc_q, acc_d;
  logic [fta_pkg::PeriodW-1:0]       period_q;
  logic                              period_ok_q, period_ok_d;
  logic [TickW-1:0]                  ticks_q, ticks_d;
  logic [fta_pkg::CountW-1:0]        frame_q, tick_q;
  logic [fta_pkg::AlphaW-1:0]        alpha_q;

  // Output register.
  logic [fta_pkg::CountW-1:0]        frame_out_q, tick_out_q;
  logic [TickW-1:0]                  ticks_out_q;
  logic signed [fta_pkg::DeltaW-1:0] raw_out_q;
  logic [fta_pkg::MaxDeltaW-1:0]     clamped_out_q;
  logic [fta_pkg::AlphaW-1:0]        alpha_out_q;

  logic [fta_pkg::MaxDeltaW-1:0] max_delta;
  logic [fta_pkg::DeltaW-1:0]    raw_u;
  logic [fta_pkg::RateW-1:0]     eff_rate;
  logic [CmpW-1:0]               lim_raw;
  logic [TickW-1:0]              limit;
  logic [fta_pkg::AccW-1:0]      period_ext;
  logic                          acc_ge_period;

  // Divider interface.
  logic [fta_pkg::PeriodW-1:0] div_rem_init;
  logic [fta_pkg::NumW-1:0]    div_num;
  logic [fta_pkg::StepW-1:0]   div_steps;
  logic [fta_pkg::PeriodW-1:0] div_dsr;
  logic [fta_pkg::QuoW-1:0]    div_quo;
  logic [fta_pkg::PeriodW-1:0] div_rem;
  logic                        div_done;

  // Delta zeroing and clamping.
  assign raw_u     = $unsigned(delta_ns_i);
  assign max_delta = (cfg_i.max_delta == '0) ? fta_pkg::FALLBACK_MAX_DELTA : cfg_i.max_delta;

  always_comb begin
    if (raw_u[fta_pkg::DeltaW-1] || (raw_u == '0)) begin
      clamped_d = '0;
    end else if (raw_u < {2'b00, max_delta}) begin
      clamped_d = raw_u[fta_pkg::MaxDeltaW-1:0];
    end else begin
      clamped_d = max_delta;
    end
  end

  // Effective tick rate and catch-up limit.
  assign eff_rate = (cfg_i.tick_rate < fta_pkg::MIN_TICK_RATE) ?
                    fta_pkg::FALLBACK_TICK_RATE : cfg_i.tick_rate;
  assign lim_raw  = (cfg_i.max_catch_up == '0) ? CmpW'(1) : CmpW'(cfg_i.max_catch_up);
  assign limit    = (lim_raw > CmpW'(MAX_CATCH_UP_LIMIT)) ?
                    TickW'(MAX_CATCH_UP_LIMIT) : TickW'(lim_raw);

  assign period_ext    = {{(fta_pkg::AccW-fta_pkg::PeriodW){1'b0}}, period_q};
  assign acc_ge_period = acc_q >= period_ext;

  // Divider operand selection.
  always_comb begin
    unique case (cmd_i.div_mode)
      fta_pkg::DIV_PERIOD: begin
        div_rem_init = '0;
        div_num      = {fta_pkg::NS_PER_SECOND, 2'b00};
        div_steps    = fta_pkg::PERIOD_STEPS;
        div_dsr      = {{(fta_pkg::PeriodW-fta_pkg::RateW){1'b0}}, eff_rate};
      end
      fta_pkg::DIV_MOD: begin
        div_rem_init = '0;
        div_num      = acc_q;
        div_steps    = fta_pkg::MOD_STEPS;
        div_dsr      = period_q;
      end
      fta_pkg::DIV_ALPHA: begin
        div_rem_init = acc_q[fta_pkg::PeriodW-1:0];
        div_num      = '0;
        div_steps    = fta_pkg::ALPHA_STEPS;
        div_dsr      = period_q;
      end
      default: begin
        div_rem_init = '0;
        div_num      = '0;
        div_steps    = fta_pkg::ALPHA_STEPS;
        div_dsr      = period_q;
      end
    endcase
  end

  fta_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .init_rem_i  (div_rem_init),
    .dividend_i  (div_num),
    .steps_i     (div_steps),
    .divisor_i   (div_dsr),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  // Accumulator, tick count and period cache updates.
  always_comb begin
    acc_d       = acc_q;
    ticks_d     = ticks_q;
    period_ok_d = period_ok_q;
    if (rate_wr_i) begin
      period_ok_d = 1'b0;
    end else if (cmd_i.period_load) begin
      period_ok_d = 1'b1;
    end
    if (cmd_i.acc_add) begin
      acc_d   = acc_q + {{(fta_pkg::AccW-fta_pkg::MaxDeltaW){1'b0}}, clamped_q};
      ticks_d = '0;
    end else if (cmd_i.tick_step) begin
      acc_d   = acc_q - period_ext;
      ticks_d = ticks_q + 1'b1;
    end else if (cmd_i.mod_load) begin
      acc_d = {{(fta_pkg::AccW-fta_pkg::PeriodW){1'b0}}, div_rem};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ticks_q     <= '0;
      period_ok_q <= 1'b0;
      frame_q     <= '0;
      tick_q      <= '0;
    end else begin
      acc_q       <= acc_d;
      ticks_q     <= ticks_d;
      period_ok_q <= period_ok_d;
      if (cmd_i.tick_step) begin
        tick_q <= tick_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        frame_q <= frame_q + 1'b1;
      end
    end
  end

  // Payload registers: captured item, period, alpha and the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      raw_q     <= delta_ns_i;
      clamped_q <= clamped_d;
    end
    if (cmd_i.period_load) begin
      period_q <= div_quo[fta_pkg::PeriodW-1:0];
    end
    if (cmd_i.alpha_load) begin
      alpha_q <= (div_quo > fta_pkg::QuoW'(fta_pkg::ALPHA_ONE)) ?
                 fta_pkg::ALPHA_ONE : div_quo[fta_pkg::AlphaW-1:0];
    end
    if (cmd_i.out_load) begin
      frame_out_q   <= frame_q;
      tick_out_q    <= tick_q;
      ticks_out_q   <= ticks_q;
      raw_out_q     <= raw_q;
      clamped_out_q <= clamped_q;
      alpha_out_q   <= alpha_q;
    end
  end

  // Status toward the controller.
  assign stat_o.period_ok = period_ok_q;
  assign stat_o.can_tick  = acc_ge_period && (ticks_q < limit);
  assign stat_o.need_mod  = acc_ge_period && (ticks_q == limit);
  assign stat_o.div_done  = div_done;

  assign frame_number_o     = frame_out_q;
  assign sim_tick_count_o   = tick_out_q;
  assign ticks_taken_o      = ticks_out_q;
  assign raw_delta_ns_o     = raw_out_q;
  assign clamped_delta_ns_o = clamped_out_q;
  assign blend_alpha_o      = alpha_out_q;

`ifndef NO_ASSERTIONS
  // A frame never reports more ticks than the effective limit.
  a_ticks_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> ticks_q <= limit)
    else $error("ticks taken exceed the catch-up limit");

  // The alpha division needs a remainder below the period.
  a_alpha_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_start && (cmd_i.div_mode == fta_pkg::DIV_ALPHA)) |-> (acc_q < period_ext))
    else $error("alpha division started with accumulator not below the period");

  // The tick loop only runs on a valid cached period.
  a_period_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_add |-> period_ok_q)
    else $error("accumulation started without a valid period");
`endif

endmodule

@@ sv/fta_ctrl.sv @@
// ----------------------------------------------------------------------------
// Fixed-timestep accumulator controller
// Sequences one frame: period refresh, accumulate, tick loop, stall modulo,
// alpha division and the output transfer.
// ----------------------------------------------------------------------------
module fta_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  fta_pkg::stat_t stat_i,
  output fta_pkg::cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_PDIV_GO  = 10'b0000000010,
    S_PDIV     = 10'b0000000100,
    S_ADD      = 10'b0000001000,
    S_TICK     = 10'b0000010000,
    S_MOD_GO   = 10'b0000100000,
    S_MOD      = 10'b0001000000,
    S_ALPHA_GO = 10'b0010000000,
    S_ALPHA    = 10'b0100000000,
    S_OUT      = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and command decode.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.div_mode = fta_pkg::DIV_ALPHA;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = stat_i.period_ok ? S_ADD : S_PDIV_GO;
        end
      end
      S_PDIV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_mode  = fta_pkg::DIV_PERIOD;
        state_d = S_PDIV;
      end
      S_PDIV: begin
        if (stat_i.div_done) begin
          cmd_o.period_load = 1'b1;
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.acc_add = 1'b1;
        state_d = S_TICK;
      end
      S_TICK: begin
        if (stat_i.can_tick) begin
          cmd_o.tick_step = 1'b1;
        end else if (stat_i.need_mod) begin
          state_d = S_MOD_GO;
        end else begin
          state_d = S_ALPHA_GO;
        end
      end
      S_MOD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_mode  = fta_pkg::DIV_MOD;
        state_d = S_MOD;
      end
      S_MOD: begin
        if (stat_i.div_done) begin
          cmd_o.mod_load = 1'b1;
          state_d = S_ALPHA_GO;
        end
      end
      S_ALPHA_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_mode  = fta_pkg::DIV_ALPHA;
        state_d = S_ALPHA;
      end
      S_ALPHA: begin
        if (stat_i.div_done) begin
          cmd_o.alpha_load = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set by a load, cleared by a completed transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // The divider only finishes while the controller waits for it.
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (state_q == S_PDIV || state_q == S_MOD || state_q == S_ALPHA))
    else $error("divider finished outside a wait state");

  // An accepted frame blocks the input until its result is loaded.
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");
`endif

endmodule

@@ sv/fixed_timestep_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// Fixed-timestep accumulator core
// Top level: configuration registers, frame controller and datapath.
// ----------------------------------------------------------------------------
// Each input transfer is one frame delta in nanoseconds; each frame yields one
// output transfer with the frame index, total ticks, ticks of this frame, the
// raw and clamped delta and the Q1.16 interpolation alpha. One frame at a time
// is processed. The tick loop does one subtract per cycle for each tick, and
// the alpha division runs in the shared one-bit-per-cycle divider. The first
// frame after reset or after a tick-rate write first recomputes the period in
// that divider, and a frame that hits the catch-up limit with a full period
// left also runs a modulo there. A finished result waits in an output
// register, so the next frame is accepted while it is still stalled.
// ----------------------------------------------------------------------------
module fixed_timestep_accumulator_core #(
  parameter int unsigned MAX_CATCH_UP_LIMIT = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fta_pkg::AddrW-1:0]         paddr,
  input  logic [fta_pkg::DataW-1:0]         pwdata,
  output logic [fta_pkg::DataW-1:0]         prdata,
  output logic                              pready,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [fta_pkg::DeltaW-1:0] delta_ns_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fta_pkg::CountW-1:0]        frame_number_o,
  output logic [fta_pkg::CountW-1:0]        sim_tick_count_o,
  output logic [$clog2(MAX_CATCH_UP_LIMIT+1)-1:0] ticks_taken_o,
  output logic signed [fta_pkg::DeltaW-1:0] raw_delta_ns_o,
  output logic [fta_pkg::MaxDeltaW-1:0]     clamped_delta_ns_o,
  output logic [fta_pkg::AlphaW-1:0]        blend_alpha_o
);

  fta_pkg::cfg_t  cfg;
  fta_pkg::cmd_t  cmd;
  fta_pkg::stat_t stat;
  logic           rate_wr;

  // Configuration registers.
  fta_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .rate_wr_o (rate_wr)
  );

  // Frame sequencer.
  fta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and state.
  fta_dpath #(
    .MAX_CATCH_UP_LIMIT (MAX_CATCH_UP_LIMIT)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .rate_wr_i          (rate_wr),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .delta_ns_i         (delta_ns_i),
    .frame_number_o     (frame_number_o),
    .sim_tick_count_o   (sim_tick_count_o),
    .ticks_taken_o      (ticks_taken_o),
    .raw_delta_ns_o     (raw_delta_ns_o),
    .clamped_delta_ns_o (clamped_delta_ns_o),
    .blend_alpha_o      (blend_alpha_o)
  );

endmodule

@@ tb/sv/fixed_timestep_accumulator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-timestep accumulator core testbench
// Feeds frame deltas through the valid/stall input channel and checks every
// output transfer against a cycle-free model of the accumulator kept in this
// file. A directed table covers the field extremes, the register fallbacks
// and the catch-up cutoff. Random phases follow, each under its own register
// setting, with random gaps on the sender, random stalls on the receiver and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module fixed_timestep_accumulator_core_tb;

  localparam int unsigned CATCH_LIMIT     = 64;
  localparam int unsigned TICKS_W         = $clog2(CATCH_LIMIT + 1);
  localparam int unsigned RESET_CYCLES    = 9;
  localparam int unsigned SETTLE_CYCLES   = 160;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned PHASE_ITEMS     = 122;
  localparam int unsigned PRESSURE_AT     = 300;
  localparam int unsigned PRESSURE_HOLD   = 400;
  localparam logic [1:0]  REG_UNMAPPED    = 2'd3;

  // One output transfer of the block.
  typedef struct packed {
    logic [fta_pkg::CountW-1:0]    frame_number;
    logic [fta_pkg::CountW-1:0]    sim_ticks;
    logic [TICKS_W-1:0]            ticks_taken;
    logic [fta_pkg::DeltaW-1:0]    raw_delta;
    logic [fta_pkg::MaxDeltaW-1:0] clamped_delta;
    logic [fta_pkg::AlphaW-1:0]    alpha;
  } frame_result_t;

  typedef enum logic { ROW_FRAME, ROW_WRITE } row_kind_e;

  // One line of the directed stimulus.
  typedef struct packed {
    row_kind_e     kind;
    logic [1:0]    reg_idx;
    logic [31:0]   value;
    logic [31:0]   delta;
    logic          known;
    frame_result_t want;
  } directed_row_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [fta_pkg::AddrW-1:0]           paddr;
  logic [fta_pkg::DataW-1:0]           pwdata;
  logic [fta_pkg::DataW-1:0]           prdata;
  logic                                pready;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic signed [fta_pkg::DeltaW-1:0]   delta_ns_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic [fta_pkg::CountW-1:0]          frame_number_o;
  logic [fta_pkg::CountW-1:0]          sim_tick_count_o;
  logic [TICKS_W-1:0]                  ticks_taken_o;
  logic signed [fta_pkg::DeltaW-1:0]   raw_delta_ns_o;
  logic [fta_pkg::MaxDeltaW-1:0]       clamped_delta_ns_o;
  logic [fta_pkg::AlphaW-1:0]          blend_alpha_o;

  // Register shadows and accumulator state of the model.
  logic [fta_pkg::RateW-1:0]     cfg_tick_rate;
  logic [fta_pkg::MaxDeltaW-1:0] cfg_max_delta;
  logic [fta_pkg::CatchW-1:0]    cfg_catch_up;
  logic [fta_pkg::AccW-1:0]      acc_ns;
  logic [fta_pkg::CountW-1:0]    frames_seen;
  logic [fta_pkg::CountW-1:0]    ticks_total;

  frame_result_t  frames_due[$];
  directed_row_t  directed_rows[$];
  logic           row_known;
  frame_result_t  row_want;
  int unsigned    mismatch_count;
  int unsigned    idle_cycles;
  int unsigned    outputs_seen;
  bit             pressure_done;

  logic [1:0]  reg_list [3] = '{fta_pkg::REG_TICK_RATE, fta_pkg::REG_MAX_DELTA,
                                fta_pkg::REG_MAX_CATCH_UP};
  int unsigned rate_set [5] = '{1000, 30, 1023, 0, 29};
  int unsigned delta_set [5] = '{1_000_000_000, 32'h3FFF_FFFF, 1, 0, 999_999};
  int unsigned catch_set [5] = '{64, 127, 1, 0, 3};

  fixed_timestep_accumulator_core #(
    .MAX_CATCH_UP_LIMIT(CATCH_LIMIT)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .delta_ns_i         (delta_ns_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_number_o     (frame_number_o),
    .sim_tick_count_o   (sim_tick_count_o),
    .ticks_taken_o      (ticks_taken_o),
    .raw_delta_ns_o     (raw_delta_ns_o),
    .clamped_delta_ns_o (clamped_delta_ns_o),
    .blend_alpha_o      (blend_alpha_o)
  );

  // Free-running clock, 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Fixed period in ns for the current tick rate, with the low-rate fallback.
  function automatic logic [31:0] period_ns();
    logic [31:0] rate;
    rate = (cfg_tick_rate < fta_pkg::MIN_TICK_RATE) ?
           32'(fta_pkg::FALLBACK_TICK_RATE) : 32'(cfg_tick_rate);
    return 32'(fta_pkg::NS_PER_SECOND) / rate;
  endfunction

  // Advances the accumulator by one frame and returns the frame's result.
  function automatic frame_result_t predict_frame(input logic [31:0] raw);
    logic [31:0]   period;
    logic [31:0]   limit;
    logic [31:0]   max_d;
    logic [31:0]   clamped;
    logic [31:0]   ticks;
    logic [63:0]   alpha;
    frame_result_t res;
    period = period_ns();
    limit = (cfg_catch_up == 0) ? 32'd1 : 32'(cfg_catch_up);
    if (limit > CATCH_LIMIT) limit = CATCH_LIMIT;
    max_d = (cfg_max_delta == 0) ? 32'(fta_pkg::FALLBACK_MAX_DELTA) : 32'(cfg_max_delta);
    if (raw[31] || raw == 0) clamped = 0;
    else clamped = (raw < max_d) ? raw : max_d;
    acc_ns = acc_ns + clamped;
    ticks = 0;
    while (acc_ns >= period && ticks < limit) begin
      ticks_total = ticks_total + 1;
      acc_ns = acc_ns - period;
      ticks++;
    end
    // Catch-up cutoff: drop whole periods that could not be simulated.
    if (ticks == limit && acc_ns >= period) acc_ns = acc_ns % period;
    alpha = {16'd0, acc_ns, 16'd0} / {32'd0, period};
    if (alpha > 64'(fta_pkg::ALPHA_ONE)) alpha = 64'(fta_pkg::ALPHA_ONE);
    res.frame_number  = frames_seen;
    res.sim_ticks     = ticks_total;
    res.ticks_taken   = ticks[TICKS_W-1:0];
    res.raw_delta     = raw;
    res.clamped_delta = clamped[fta_pkg::MaxDeltaW-1:0];
    res.alpha         = alpha[fta_pkg::AlphaW-1:0];
    frames_seen = frames_seen + 1;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Random frame delta, mostly around the period, with noise and extremes.
  function automatic logic [31:0] random_delta();
    logic [31:0] period;
    logic [31:0] max_d;
    int unsigned pick;
    period = period_ns();
    max_d = (cfg_max_delta == 0) ? 32'(fta_pkg::FALLBACK_MAX_DELTA) : 32'(cfg_max_delta);
    pick = $urandom_range(99);
    if (pick < 45) return $urandom_range(0, 2 * period);
    if (pick < 58) return $urandom_range(0, period / 4);
    if (pick < 68) return {1'b1, 31'($urandom())};
    if (pick < 80) return $urandom();
    if (pick < 90) return max_d + $urandom_range(0, 4) - 2;
    return 32'(64'(period) * $urandom_range(1, 80) + $urandom_range(0, 999));
  endfunction

  // Sender gap: mostly none or short, a few long.
  function automatic int unsigned sender_gap();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_frame(input logic [31:0] delta);
    directed_row_t row;
    row = '0;
    row.kind = ROW_FRAME;
    row.delta = delta;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_known(input logic [31:0] delta, input logic [63:0] frame,
                                    input logic [63:0] sim, input int unsigned ticks,
                                    input logic [29:0] clamped, input logic [16:0] alpha);
    directed_row_t row;
    row = '0;
    row.kind = ROW_FRAME;
    row.delta = delta;
    row.known = 1'b1;
    row.want.frame_number  = frame;
    row.want.sim_ticks     = sim;
    row.want.ticks_taken   = ticks[TICKS_W-1:0];
    row.want.raw_delta     = delta;
    row.want.clamped_delta = clamped;
    row.want.alpha         = alpha;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_write(input logic [1:0] idx, input logic [31:0] value);
    directed_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.value = value;
    directed_rows.push_back(row);
  endfunction

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      fta_pkg::REG_TICK_RATE:    cfg_tick_rate = value[fta_pkg::RateW-1:0];
      fta_pkg::REG_MAX_DELTA:    cfg_max_delta = value[fta_pkg::MaxDeltaW-1:0];
      fta_pkg::REG_MAX_CATCH_UP: cfg_catch_up  = value[fta_pkg::CatchW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Reads back every register and compares it with its shadow.
  task automatic check_regs();
    logic [31:0] want;
    foreach (reg_list[i]) begin
      case (reg_list[i])
        fta_pkg::REG_TICK_RATE:    want = 32'(cfg_tick_rate);
        fta_pkg::REG_MAX_DELTA:    want = 32'(cfg_max_delta);
        default:                   want = 32'(cfg_catch_up);
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_list[i], 2'b00};
      @(negedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      check_field("prdata", 64'(want), 64'(prdata));
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Offers one frame delta after an optional gap and waits for the transfer.
  task automatic send_frame(input logic [31:0] delta, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    delta_ns_i <= delta;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Waits until every pending frame has come out, then lets the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Input and output monitor: predicts on input transfers, checks outputs.
  always @(posedge clk_i) begin : monitor
    frame_result_t want;
    bit            moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        want = predict_frame(delta_ns_i);
        if (row_known) want = row_want;
        frames_due.push_back(want);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        outputs_seen++;
        if (frames_due.size() == 0) begin
          $display("%0t: output transfer with no frame pending", $time);
          mismatch_count++;
        end else begin
          want = frames_due.pop_front();
          check_field("frame_number", want.frame_number, frame_number_o);
          check_field("sim_tick_count", want.sim_ticks, sim_tick_count_o);
          check_field("ticks_taken", 64'(want.ticks_taken), 64'(ticks_taken_o));
          check_field("raw_delta_ns", 64'(want.raw_delta), {32'd0, raw_delta_ns_o});
          check_field("clamped_delta_ns", 64'(want.clamped_delta), 64'(clamped_delta_ns_o));
          check_field("blend_alpha", 64'(want.alpha), 64'(blend_alpha_o));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin
    @(posedge rst_ni);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("fixed_timestep_accumulator_core_tb: errors");
    $finish;
  end

  // Receiver: random stalls, free stretches and one long hold-off.
  initial begin : receiver
    int unsigned pick;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!pressure_done && outputs_seen >= PRESSURE_AT) begin
        out_stall_i <= 1'b1;
        repeat (PRESSURE_HOLD) @(negedge clk_i);
        pressure_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 60)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ((pick < 88) ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(negedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end
    end
  end

  // Main sequence: reset, directed table, random phases, final verdict.
  initial begin : stimulus
    logic [31:0] rate;
    logic [31:0] max_d;
    logic [31:0] catch_up;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    delta_ns_i     = '0;
    row_known      = 1'b0;
    row_want       = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    outputs_seen   = 0;
    pressure_done  = 1'b0;
    cfg_tick_rate  = fta_pkg::RST_TICK_RATE;
    cfg_max_delta  = fta_pkg::RST_MAX_DELTA;
    cfg_catch_up   = fta_pkg::RST_MAX_CATCH_UP;
    acc_ns         = '0;
    frames_seen    = '0;
    ticks_total    = '0;

    // Reset settings: period 8333333 ns, max delta 1e8, at most five ticks per frame.
    add_known(32'd0,         64'd0, 64'd0, 0, 30'd0, 17'd0);
    add_known(32'hFFFF_FFFF, 64'd1, 64'd0, 0, 30'd0, 17'd0);
    add_known(32'h8000_0000, 64'd2, 64'd0, 0, 30'd0, 17'd0);
    add_known(32'h7FFF_FFFF, 64'd3, 64'd5, 5, 30'd100_000_000, 17'd0);
    add_known(32'd1,         64'd4, 64'd5, 0, 30'd1, 17'd0);
    add_frame(32'd8_333_327);
    add_frame(32'd1);
    add_frame(32'd100_000_000);
    add_frame(32'd100_000_001);
    add_frame(32'd99_999_999);
    // Zero catch-up acts as one tick, so the cutoff trims the remainder.
    add_write(fta_pkg::REG_MAX_CATCH_UP, 32'd0);
    add_frame(32'd20_000_000);
    // Catch-up above the limit saturates; zero max delta falls back.
    add_write(fta_pkg::REG_MAX_CATCH_UP, 32'd127);
    add_write(fta_pkg::REG_TICK_RATE, 32'd1000);
    add_write(fta_pkg::REG_MAX_DELTA, 32'd0);
    add_frame(32'h7FFF_FFFF);
    add_frame(32'd2_500_000);
    // Tick rates below the minimum fall back to the default rate.
    add_write(fta_pkg::REG_TICK_RATE, 32'd29);
    add_frame(32'd12_345_678);
    add_write(fta_pkg::REG_TICK_RATE, 32'd0);
    add_frame(32'd8_333_333);
    // Widest register values.
    add_write(fta_pkg::REG_TICK_RATE, 32'd1023);
    add_write(fta_pkg::REG_MAX_DELTA, 32'h3FFF_FFFF);
    add_write(fta_pkg::REG_MAX_CATCH_UP, 32'd64);
    add_frame(32'h7FFF_FFFF);
    add_frame(32'd977_516);
    add_write(fta_pkg::REG_MAX_DELTA, 32'd1);
    add_frame(32'd5);
    add_frame(32'h4000_0000);
    // A write to an unmapped register must change nothing.
    add_write(REG_UNMAPPED, 32'hFFFF_FFFF);
    add_frame(32'd3);
    add_write(fta_pkg::REG_TICK_RATE, 32'd30);
    add_write(fta_pkg::REG_MAX_DELTA, 32'd1_000_000_000);
    add_write(fta_pkg::REG_MAX_CATCH_UP, 32'd1);
    add_frame(32'd1_000_000_000);
    add_frame(32'd33_333_332);

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    check_regs();

    // Directed table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        row_known = directed_rows[i].known;
        row_want  = directed_rows[i].want;
        send_frame(directed_rows[i].delta, sender_gap());
      end
    end
    row_known = 1'b0;
    wait_idle();
    check_regs();

    // Random phases: extreme settings first, then random ones.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 5) begin
        rate     = rate_set[p];
        max_d    = delta_set[p];
        catch_up = catch_set[p];
      end else begin
        rate     = $urandom_range(0, 1023);
        max_d    = (p % 2) ? $urandom_range(0, 32'h3FFF_FFFF) : $urandom_range(1, 100_000_000);
        catch_up = $urandom_range(0, 127);
      end
      // Upper pwdata bits are random; the register keeps only its own width.
      write_reg(fta_pkg::REG_TICK_RATE, ($urandom() << fta_pkg::RateW) | rate);
      write_reg(fta_pkg::REG_MAX_DELTA, ($urandom() << fta_pkg::MaxDeltaW) | max_d);
      write_reg(fta_pkg::REG_MAX_CATCH_UP, ($urandom() << fta_pkg::CatchW) | catch_up);
      check_regs();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_frame(random_delta(), (((n / 32) % 3) == 1) ? 0 : sender_gap());
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("fixed_timestep_accumulator_core_tb: clean");
    end else begin
      $display("fixed_timestep_accumulator_core_tb: errors");
    end
    $finish;
  end

endmodule
